>>> src/drrip_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package drrip_pkg;

  // Cache geometry and policy limits
  localparam int NUM_SETS     = 2048;
  localparam int NUM_WAYS     = 16;
  localparam int REREF_MAX    = 3;
  localparam int SELECTOR_MAX = 1023;
  localparam int SEL_RESET    = SELECTOR_MAX / 2;

  // Field widths
  localparam int SET_W    = 11;
  localparam int WAY_W    = 4;
  localparam int DRAW_W   = 5;
  localparam int VAL_W    = 2;
  localparam int SEL_W    = 10;
  localparam int MODE_W   = 2;
  localparam int ROW_W    = NUM_WAYS * VAL_W;

  // Leader set groups, taken from the low set index bits
  localparam int             LEADER_W    = 4;
  localparam logic [LEADER_W-1:0] SRRIP_GROUP = 4'h0;
  localparam logic [LEADER_W-1:0] BRRIP_GROUP = 4'h1;

  // Stream widths
  localparam int IN_DATA_W  = 24;
  localparam int IN_USER_W  = 8;
  localparam int OUT_DATA_W = 24;

  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [MODE_W-1:0] {
    MODE_VICTIM = 2'd0,
    MODE_HIT    = 2'd1,
    MODE_FILL   = 2'd2
  } mode_e;

  // Classified event handed from front to back
  typedef struct packed {
    mode_e              mode;
    logic [SET_W-1:0]   set_index;
    logic [WAY_W-1:0]   way_index;
    logic [VAL_W-1:0]   written_value;
    logic               used_bimodal;
    logic [SEL_W-1:0]   selector_value;
  } op_t;

  typedef struct packed {
    logic [WAY_W-1:0]   victim_way;
    logic [VAL_W-1:0]   written_value;
    logic               used_bimodal;
    logic [SEL_W-1:0]   selector_value;
  } res_t;

endpackage

`default_nettype wire

>>> src/drrip_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module drrip_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> src/drrip_front.sv
`timescale 1ns / 1ps
`default_nettype none

module drrip_front
  import drrip_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              accept_i,
  input  wire logic [MODE_W-1:0] mode_i,
  input  wire logic [SET_W-1:0]  set_index_i,
  input  wire logic [WAY_W-1:0]  way_index_i,
  input  wire logic [DRAW_W-1:0] bimodal_draw_i,
  output op_t                    op_o
);

  logic [SEL_W-1:0]    sel_q, sel_d;
  logic [LEADER_W-1:0] group;
  logic                use_b;
  mode_e               mode;

  assign mode  = mode_e'(mode_i);
  assign group = set_index_i[LEADER_W-1:0];

  always_comb begin
    sel_d = sel_q;
    use_b = 1'b0;
    op_o.mode           = mode;
    op_o.set_index      = set_index_i;
    op_o.way_index      = way_index_i;
    op_o.written_value  = '0;
    op_o.used_bimodal   = 1'b0;
    case (mode)
      MODE_HIT: begin
        // leaders steer the selector, followers leave it
        if (group == SRRIP_GROUP) begin
          if (sel_q < SEL_W'(SELECTOR_MAX)) sel_d = sel_q + 1'b1;
        end else if (group == BRRIP_GROUP) begin
          if (sel_q != '0) sel_d = sel_q - 1'b1;
        end
      end
      MODE_FILL: begin
        if (group == SRRIP_GROUP) begin
          use_b = 1'b0;
        end else if (group == BRRIP_GROUP) begin
          use_b = 1'b1;
        end else begin
          use_b = sel_q < SEL_W'(SEL_RESET);
        end
        op_o.used_bimodal  = use_b;
        op_o.written_value = (use_b && bimodal_draw_i == '0) ? VAL_W'(REREF_MAX)
                                                              : VAL_W'(REREF_MAX - 1);
      end
      default: begin
      end
    endcase
    op_o.selector_value = sel_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= SEL_W'(SEL_RESET);
    end else if (accept_i) begin
      sel_q <= sel_d;
    end
  end

endmodule

`default_nettype wire

>>> src/drrip_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module drrip_queue
  import drrip_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire op_t  data_i,
  input  wire logic pop_i,
  output op_t       head_o,
  output logic      full_o,
  output logic      empty_o
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  op_t             mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [PTR_W:0]   cnt_q;

  assign full_o  = cnt_q == (PTR_W+1)'(QUEUE_DEPTH);
  assign empty_o = cnt_q == '0;
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i || pop_i)
    else $error("queue push while full");

endmodule

`default_nettype wire

>>> src/drrip_back.sv
`timescale 1ns / 1ps
`default_nettype none

module drrip_back
  import drrip_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire op_t  head_i,
  input  wire logic empty_i,
  output logic      pop_o,
  output logic      clearing_o,
  input  wire logic out_ready_i,
  output logic      out_valid_o,
  output res_t      res_o
);

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_EXEC  = 3'b100
  } state_e;

  state_e            state_q, state_d;
  logic [SET_W-1:0]  clr_q;
  op_t               op_q;
  logic              out_valid_q;
  res_t              res_q;

  logic              ram_we, ram_re, load_out, out_free, row_write;
  logic [SET_W-1:0]  ram_waddr;
  logic [ROW_W-1:0]  ram_wdata, rdata, new_row;
  logic [VAL_W-1:0]  top;
  logic [WAY_W-1:0]  victim;

  drrip_ram #(
    .WIDTH(ROW_W),
    .DEPTH(NUM_SETS)
  ) u_rows (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(head_i.set_index),
    .rdata_o(rdata)
  );

  // Find the oldest value in the row and the lowest way that holds it, and build the new row
  always_comb begin
    logic [REREF_MAX:0] present;
    logic [VAL_W-1:0]   delta;
    for (int k = 0; k <= REREF_MAX; k++) begin
      present[k] = 1'b0;
      for (int w = 0; w < NUM_WAYS; w++) begin
        if (rdata[w*VAL_W +: VAL_W] == VAL_W'(k)) present[k] = 1'b1;
      end
    end
    top = '0;
    for (int k = 0; k <= REREF_MAX; k++) begin
      if (present[k]) top = VAL_W'(k);
    end
    victim = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (rdata[w*VAL_W +: VAL_W] == top) victim = WAY_W'(w);
    end
    delta     = VAL_W'(REREF_MAX) - top;
    new_row   = rdata;
    row_write = 1'b1;
    case (op_q.mode)
      MODE_VICTIM: begin
        for (int w = 0; w < NUM_WAYS; w++) begin
          new_row[w*VAL_W +: VAL_W] = rdata[w*VAL_W +: VAL_W] + delta;
        end
      end
      MODE_HIT:  new_row[op_q.way_index*VAL_W +: VAL_W] = '0;
      MODE_FILL: new_row[op_q.way_index*VAL_W +: VAL_W] = op_q.written_value;
      default:   row_write = 1'b0;
    endcase
  end

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d   = state_q;
    pop_o     = 1'b0;
    ram_re    = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = op_q.set_index;
    ram_wdata = new_row;
    load_out  = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = {NUM_WAYS{VAL_W'(REREF_MAX)}};
        if (clr_q == SET_W'(NUM_SETS - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          ram_re  = 1'b1;
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          load_out = 1'b1;
          ram_we   = row_write;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) op_q <= head_i;
    if (load_out) begin
      res_q.victim_way     <= (op_q.mode == MODE_VICTIM) ? victim : '0;
      res_q.written_value  <= op_q.written_value;
      res_q.used_bimodal   <= op_q.used_bimodal;
      res_q.selector_value <= op_q.selector_value;
    end
  end

  assign clearing_o  = state_q == ST_CLEAR;
  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

  a_write_not_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> state_q != ST_IDLE)
    else $error("row write outside clear or execute");

  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> state_q == ST_IDLE && !empty_i)
    else $error("pop outside idle or from empty queue");

  a_exec_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXEC && out_free) |=> out_valid_q && state_q == ST_IDLE)
    else $error("executed event left no result");

endmodule

`default_nettype wire

>>> src/drrip_cache_replacement.sv
// DRRIP replacement state for a 2048-set, 16-way cache with 2-bit re-reference values.
// Each request carries a mode in s_axis_tuser (victim query, hit, fill) and a set, way and
// random draw in s_axis_tdata; every request yields exactly one result on the master side.
// The front end classifies the request at once (leader group, policy choice, inserted value)
// and keeps the 10-bit policy selector, so the selector_value of a result is the selector
// after that request in arrival order. A four-entry queue decouples it from the back end,
// which holds the set rows in a single RAM and does one read-modify-write per request
// (mode 3 only reads): row read, then row write held while the master stalls, one at a time.
// A victim query ages the whole set in that one step and names the lowest oldest way.
// After reset the back end sweeps all 2048 rows to the distant value, one row a cycle, and
// s_axis_tready stays low until the sweep is done.
`timescale 1ns / 1ps
`default_nettype none

module drrip_cache_replacement
  import drrip_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // tdata: set_index[10:0], way_index[14:11], bimodal_draw[19:15], zero fill above
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  // tuser: mode[1:0], zero fill above
  input  wire logic [IN_USER_W-1:0]  s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // tdata: victim_way[3:0], written_value[5:4], used_bimodal[6], selector_value[16:7],
  // zero fill above
  output logic [OUT_DATA_W-1:0]      m_axis_tdata
);

  op_t  front_op, head_op;
  res_t res;
  logic accept, q_full, q_empty, pop, clearing;

  // hold requests off while the rows are swept or the queue is full
  assign s_axis_tready = !q_full && !clearing;
  assign accept        = s_axis_tvalid && s_axis_tready;

  drrip_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .mode_i        (s_axis_tuser[MODE_W-1:0]),
    .set_index_i   (s_axis_tdata[SET_W-1:0]),
    .way_index_i   (s_axis_tdata[SET_W +: WAY_W]),
    .bimodal_draw_i(s_axis_tdata[SET_W+WAY_W +: DRAW_W]),
    .op_o          (front_op)
  );

  drrip_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (accept),
    .data_i (front_op),
    .pop_i  (pop),
    .head_o (head_op),
    .full_o (q_full),
    .empty_o(q_empty)
  );

  drrip_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head_op),
    .empty_i    (q_empty),
    .pop_o      (pop),
    .clearing_o (clearing),
    .out_ready_i(m_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .res_o      (res)
  );

  // pack the result, lowest field first
  assign m_axis_tdata = {
    (OUT_DATA_W - WAY_W - VAL_W - 1 - SEL_W)'(0),
    res.selector_value,
    res.used_bimodal,
    res.written_value,
    res.victim_way
  };

endmodule

`default_nettype wire

>>> test/drrip_cache_replacement_checker.sv
`timescale 1ns / 1ps

module drrip_cache_replacement_checker
  import drrip_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  input  wire logic                  s_axis_tready,
  // tdata: set_index[10:0], way_index[14:11], bimodal_draw[19:15], zero fill above
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  // tuser: mode[1:0], zero fill above
  input  wire logic [IN_USER_W-1:0]  s_axis_tuser,
  input  wire logic                  m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // tdata: victim_way[3:0], written_value[5:4], used_bimodal[6], selector_value[16:7]
  input  wire logic [OUT_DATA_W-1:0] m_axis_tdata,
  output int                         failure_count_o,
  output int                         pending_results_o
);

  logic [VAL_W-1:0] line_rrpv [NUM_SETS][NUM_WAYS];
  logic [SEL_W-1:0] policy_sel;
  res_t             expected_results [$];
  int               failures;

  // Apply one request to the shadow state and return the result it should give.
  function automatic res_t apply_request(input logic [MODE_W-1:0] mode,
                                         input logic [SET_W-1:0]  set_idx,
                                         input logic [WAY_W-1:0]  way,
                                         input logic [DRAW_W-1:0] draw);
    res_t                r;
    logic [VAL_W-1:0]    top;
    logic [VAL_W-1:0]    bump;
    logic [WAY_W-1:0]    pick;
    logic [LEADER_W-1:0] grp;
    logic                brrip;
    r    = '0;
    top  = '0;
    pick = '0;
    grp  = set_idx[LEADER_W-1:0];
    case (mode)
      MODE_VICTIM: begin
        for (int w = 0; w < NUM_WAYS; w++)
          if (line_rrpv[set_idx][w] > top) top = line_rrpv[set_idx][w];
        for (int w = NUM_WAYS - 1; w >= 0; w--)
          if (line_rrpv[set_idx][w] == top) pick = WAY_W'(w);
        // age the whole set in one go so the oldest lines reach the distant value
        bump = VAL_W'(REREF_MAX) - top;
        for (int w = 0; w < NUM_WAYS; w++)
          line_rrpv[set_idx][w] = line_rrpv[set_idx][w] + bump;
        r.victim_way = pick;
      end
      MODE_HIT: begin
        line_rrpv[set_idx][way] = '0;
        if (grp == SRRIP_GROUP && policy_sel != SEL_W'(SELECTOR_MAX)) begin
          policy_sel = policy_sel + 1'b1;
        end else if (grp == BRRIP_GROUP && policy_sel != '0) begin
          policy_sel = policy_sel - 1'b1;
        end
      end
      MODE_FILL: begin
        if (grp == BRRIP_GROUP) begin
          brrip = 1'b1;
        end else if (grp == SRRIP_GROUP) begin
          brrip = 1'b0;
        end else begin
          brrip = policy_sel < SEL_W'(SEL_RESET);
        end
        r.written_value = (brrip && draw == '0) ? VAL_W'(REREF_MAX) : VAL_W'(REREF_MAX - 1);
        r.used_bimodal  = brrip;
        line_rrpv[set_idx][way] = r.written_value;
      end
      default: ;
    endcase
    r.selector_value = policy_sel;
    return r;
  endfunction

  always @(posedge clk_i) begin
    res_t got;
    res_t want;
    if (!rst_ni) begin
      for (int s = 0; s < NUM_SETS; s++)
        for (int w = 0; w < NUM_WAYS; w++) line_rrpv[s][w] = VAL_W'(REREF_MAX);
      policy_sel = SEL_W'(SEL_RESET);
      expected_results.delete();
      failures = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_results.push_back(apply_request(s_axis_tuser[MODE_W-1:0],
                                                 s_axis_tdata[SET_W-1:0],
                                                 s_axis_tdata[SET_W +: WAY_W],
                                                 s_axis_tdata[SET_W+WAY_W +: DRAW_W]));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.victim_way     = m_axis_tdata[WAY_W-1:0];
        got.written_value  = m_axis_tdata[WAY_W +: VAL_W];
        got.used_bimodal   = m_axis_tdata[WAY_W+VAL_W];
        got.selector_value = m_axis_tdata[WAY_W+VAL_W+1 +: SEL_W];
        if (expected_results.size() == 0) begin
          failures++;
          if (failures <= 10)
            $display("unexpected result: victim %0d written %0d bimodal %0b selector %0d",
                     got.victim_way, got.written_value, got.used_bimodal,
                     got.selector_value);
        end else begin
          want = expected_results.pop_front();
          if (got.victim_way != want.victim_way || got.written_value != want.written_value ||
              got.used_bimodal != want.used_bimodal ||
              got.selector_value != want.selector_value) begin
            failures++;
            if (failures <= 10)
              $display({"result mismatch: expected victim %0d written %0d bimodal %0b ",
                        "selector %0d, got victim %0d written %0d bimodal %0b selector %0d"},
                       want.victim_way, want.written_value, want.used_bimodal,
                       want.selector_value, got.victim_way, got.written_value,
                       got.used_bimodal, got.selector_value);
          end
        end
      end
    end
    failure_count_o   <= failures;
    pending_results_o <= expected_results.size();
  end

endmodule

>>> test/drrip_cache_replacement_tb.sv
`timescale 1ns / 1ps

module drrip_cache_replacement_tb;
  import drrip_pkg::*;

  // Mode 3 has no meaning in the block; it must leave all state alone.
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  // Hit bias of a stimulus phase: none, towards BRRIP leaders, towards SRRIP leaders.
  localparam int DRIFT_NONE = 0;
  localparam int DRIFT_DOWN = 1;
  localparam int DRIFT_UP   = 2;

  // Slowest correct run: about 650 requests, each with the longest random gap, a row
  // read-modify-write and the longest result stall, plus the row sweep after reset.
  // The limit sits several times above that.
  localparam int CYCLE_LIMIT = 150000;
  localparam int TAIL_CYCLES = 16;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // tdata: set_index[10:0], way_index[14:11], bimodal_draw[19:15], zero fill above
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  // tuser: mode[1:0], zero fill above
  logic [IN_USER_W-1:0]  s_axis_tuser  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // tdata: victim_way[3:0], written_value[5:4], used_bimodal[6], selector_value[16:7]
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  int failure_count;
  int pending_results;
  int cycle_count = 0;
  int sent_count  = 0;
  bit no_idle     = 1'b0;   // when set, both sides run flat out

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  drrip_cache_replacement dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  drrip_cache_replacement_checker u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .s_axis_tvalid     (s_axis_tvalid),
    .s_axis_tready     (s_axis_tready),
    .s_axis_tdata      (s_axis_tdata),
    .s_axis_tuser      (s_axis_tuser),
    .m_axis_tvalid     (m_axis_tvalid),
    .m_axis_tready     (m_axis_tready),
    .m_axis_tdata      (m_axis_tdata),
    .failure_count_o   (failure_count),
    .pending_results_o (pending_results)
  );

  // Half the time stay within 64 sets so that rows are revisited and aged;
  // otherwise roam over the whole index range.
  function automatic logic [SET_W-1:0] pick_set();
    if ($urandom_range(0, 1) == 0)
      return SET_W'(($urandom_range(0, 3) << LEADER_W) | $urandom_range(0, 15));
    return SET_W'($urandom_range(0, NUM_SETS - 1));
  endfunction

  // Favour a zero draw so the distant BRRIP insertion turns up often.
  function automatic logic [DRAW_W-1:0] pick_draw();
    if ($urandom_range(0, 3) == 0) return '0;
    return DRAW_W'($urandom_range(0, 31));
  endfunction

  function automatic logic [MODE_W-1:0] pick_mode();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return MODE_UNUSED;
    if (r < 30) return MODE_VICTIM;
    if (r < 65) return MODE_HIT;
    return MODE_FILL;
  endfunction

  // Present one request after a random gap and hold it until accepted.
  task automatic send_request(input logic [MODE_W-1:0] mode,
                              input logic [SET_W-1:0]  set_idx,
                              input logic [WAY_W-1:0]  way,
                              input logic [DRAW_W-1:0] draw);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_DATA_W - SET_W - WAY_W - DRAW_W){1'b0}}, draw, way, set_idx};
    s_axis_tuser  <= {{(IN_USER_W - MODE_W){1'b0}}, mode};
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    sent_count++;
  endtask

  // Drop valid and hold off until every outstanding result has come back.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_results != 0);
  endtask

  // Touch most ways of one set with hits and fills, then query it so that the
  // set has to age before a victim turns up.
  task automatic sweep_set(input logic [SET_W-1:0] set_idx);
    int queries;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if ($urandom_range(0, 99) < 85)
        send_request($urandom_range(0, 1) ? MODE_HIT : MODE_FILL, set_idx, WAY_W'(w),
                     pick_draw());
    end
    queries = $urandom_range(1, 3);
    repeat (queries)
      send_request(MODE_VICTIM, set_idx, WAY_W'($urandom_range(0, NUM_WAYS - 1)),
                   pick_draw());
  endtask

  // A drifting phase sends mostly hits into one leader group to push the selector
  // well away from the threshold; the rest is mixed traffic that sees the policy there.
  task automatic random_request(input int drift);
    logic [SET_W-1:0] set_idx;
    set_idx = pick_set();
    if (drift != DRIFT_NONE && $urandom_range(0, 99) < 94) begin
      set_idx[LEADER_W-1:0] = (drift == DRIFT_DOWN) ? BRRIP_GROUP : SRRIP_GROUP;
      send_request(MODE_HIT, set_idx, WAY_W'($urandom_range(0, NUM_WAYS - 1)), pick_draw());
    end else begin
      send_request(pick_mode(), set_idx, WAY_W'($urandom_range(0, NUM_WAYS - 1)),
                   pick_draw());
    end
  endtask

  task automatic run_phase(input int drift, input int count);
    int target;
    target = sent_count + count;
    while (sent_count < target) begin
      if (sent_count % 50 < 2) no_idle = ($urandom_range(0, 3) == 0);
      if (drift == DRIFT_NONE && $urandom_range(0, 3) == 0) begin
        sweep_set(pick_set());
      end else begin
        random_request(drift);
      end
    end
  endtask

  // Results side: stall a random number of cycles before taking each result.
  initial begin : result_sink
    int stall;
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 15);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
    end
  end

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("FAIL drrip_cache_replacement");
    $finish;
  end

  initial begin : stimulus
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: leader and follower policy, threshold, distant insert, unused mode.
    send_request(MODE_VICTIM, 11'd0,    4'd0,  5'd0);   // fresh set, no ageing needed
    send_request(MODE_FILL,   11'd0,    4'd0,  5'd0);   // SRRIP leader ignores the draw
    send_request(MODE_VICTIM, 11'd0,    4'd0,  5'd31);  // lowest distant way is 1
    send_request(MODE_HIT,    11'd0,    4'd15, 5'd0);   // selector up
    send_request(MODE_HIT,    11'd2047, 4'd1,  5'd31);  // follower hit leaves selector
    send_request(MODE_HIT,    11'd1,    4'd0,  5'd31);  // selector down
    send_request(MODE_HIT,    11'd17,   4'd0,  5'd0);   // below the threshold now
    send_request(MODE_FILL,   11'd2,    4'd15, 5'd0);   // follower on BRRIP, distant insert
    send_request(MODE_FILL,   11'd2047, 4'd3,  5'd31);  // follower on BRRIP, near insert
    send_request(MODE_FILL,   11'd1,    4'd7,  5'd0);   // BRRIP leader, distant insert
    send_request(MODE_FILL,   11'd1,    4'd8,  5'd31);
    send_request(MODE_HIT,    11'd16,   4'd4,  5'd0);   // back to the threshold
    send_request(MODE_FILL,   11'd2,    4'd14, 5'd0);   // at the threshold followers use SRRIP
    send_request(MODE_UNUSED, 11'd2047, 4'd15, 5'd31);
    send_request(MODE_UNUSED, 11'd0,    4'd0,  5'd0);
    send_request(MODE_FILL,   11'd1024, 4'd15, 5'd16);
    send_request(MODE_VICTIM, 11'd1,    4'd9,  5'd0);
    send_request(MODE_VICTIM, 11'd2047, 4'd0,  5'd0);
    send_request(MODE_HIT,    11'd2047, 4'd0,  5'd0);
    send_request(MODE_VICTIM, 11'd2047, 4'd15, 5'd0);

    // Let the pipeline run dry once before random traffic starts.
    drain_results();

    run_phase(DRIFT_NONE, 120);
    drain_results();
    run_phase(DRIFT_DOWN, 180);   // pull the selector well below the threshold
    run_phase(DRIFT_UP, 250);     // and push it back above
    drain_results();
    run_phase(DRIFT_NONE, 50);

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (failure_count == 0 && pending_results == 0) begin
      $display("PASS drrip_cache_replacement");
    end else begin
      $display("FAIL drrip_cache_replacement");
    end
    $finish;
  end

endmodule

>>> drrip_cache_replacement.f
src/drrip_pkg.sv
src/drrip_ram.sv
src/drrip_front.sv
src/drrip_queue.sv
src/drrip_back.sv
src/drrip_cache_replacement.sv
test/drrip_cache_replacement_checker.sv
test/drrip_cache_replacement_tb.sv
